>>> rtl/core/hcfc_pkg.sv
// ----------------------------------------------------------------------------
// hcfc_pkg
// Shared types, constants and the CRC byte update for the header and CRC-16
// frame checker.
// ----------------------------------------------------------------------------
package hcfc_pkg;

  localparam int COUNT_BITS = 10;
  localparam int LEN_BITS   = 10;
  localparam int CMP_BITS   = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [CMP_BITS-1:0]   cmp_t;

  localparam count_t COUNT_MAX = '1;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  localparam len_t        EXPECTED_LENGTH_RESET = len_t'(64);
  localparam logic [7:0]  HEADER_FIRST_RESET    = 8'h53;
  localparam logic [7:0]  HEADER_SECOND_RESET   = 8'h50;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_LENGTH = 2'd1,
    STATUS_HEADER = 2'd2,
    STATUS_CRC    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_EXPECTED_LENGTH = 2'd0,
    REG_HEADER_FIRST    = 2'd1,
    REG_HEADER_SECOND   = 2'd2
  } reg_index_t;

  typedef struct packed {
    len_t       expected_length;
    logic [7:0] header_first;
    logic [7:0] header_second;
  } cfg_t;

  typedef struct packed {
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    status_t     status;
  } result_t;

  function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/hcfc_check.sv
// ----------------------------------------------------------------------------
// hcfc_check
// Per-frame state: byte counter, header flag, two-byte delay line and CRC
// accumulator. Produces the frame verdict on the final byte.
// ----------------------------------------------------------------------------
module hcfc_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  hcfc_pkg::cfg_t    cfg,
  output hcfc_pkg::result_t result
);

  hcfc_pkg::count_t byte_count;
  hcfc_pkg::count_t byte_count_next;
  logic [15:0]      crc_acc;
  logic [15:0]      crc_next;
  logic [7:0]       delay_newer;
  logic [7:0]       delay_older;
  logic             header_good;
  logic             header_next;
  hcfc_pkg::count_t frame_len;
  hcfc_pkg::cmp_t   len_cmp;
  hcfc_pkg::cmp_t   exp_cmp;
  logic [15:0]      rx_crc;

  always_comb begin
    header_next = header_good;
    if (byte_count == '0 && data_byte != cfg.header_first) begin
      header_next = 1'b0;
    end
    if (byte_count == hcfc_pkg::count_t'(1) && data_byte != cfg.header_second) begin
      header_next = 1'b0;
    end
    crc_next = crc_acc;
    if (byte_count >= hcfc_pkg::count_t'(2)) begin
      crc_next = hcfc_pkg::crc_absorb(crc_acc, delay_older);
    end
    byte_count_next = (byte_count != hcfc_pkg::COUNT_MAX) ?
                      byte_count + hcfc_pkg::count_t'(1) : byte_count;
    frame_len = byte_count_next;
    len_cmp   = hcfc_pkg::cmp_t'(frame_len);
    exp_cmp   = hcfc_pkg::cmp_t'(cfg.expected_length);
    rx_crc    = {data_byte, delay_newer};
    result.computed_crc = crc_next;
    result.received_crc = rx_crc;
    priority if (len_cmp != exp_cmp) begin
      result.status = hcfc_pkg::STATUS_LENGTH;
    end else if (!header_next || frame_len < hcfc_pkg::count_t'(2)) begin
      result.status = hcfc_pkg::STATUS_HEADER;
    end else if (rx_crc != crc_next) begin
      result.status = hcfc_pkg::STATUS_CRC;
    end else begin
      result.status = hcfc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      crc_acc     <= hcfc_pkg::CRC_START;
      delay_newer <= '0;
      delay_older <= '0;
      header_good <= 1'b1;
    end else if (step) begin
      if (last_byte) begin
        byte_count  <= '0;
        crc_acc     <= hcfc_pkg::CRC_START;
        delay_newer <= '0;
        delay_older <= '0;
        header_good <= 1'b1;
      end else begin
        byte_count  <= byte_count_next;
        crc_acc     <= crc_next;
        delay_newer <= data_byte;
        delay_older <= delay_newer;
        header_good <= header_next;
      end
    end
  end

endmodule

>>> rtl/core/header_crc16_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// header_crc16_frame_checker_unit
// Receive-side frame checker: length, two header bytes and trailing
// CRC-16/MCRF4XX.
// ----------------------------------------------------------------------------
// Frame bytes enter on the s_ channel, one word per byte, with s_tlast on the
// final byte. One verdict word leaves on the m_ channel per frame, after the
// final byte; other bytes give no output. A byte is accepted in every cycle
// while the output side keeps up: the sustained rate is one byte per cycle,
// set by the combinational CRC byte update between the input register and
// the result register.
// A final byte taken into the input register is checked there, and its verdict
// is then registered in the result register that drives m_tvalid.
// When the receiver stalls, the verdict waits in the result register; bytes
// that give no verdict still flow, and only a final byte meeting a full
// result register holds the input register and drops s_tready.
// Registers are written on cfg_we with cfg_index and cfg_data; index 0 is
// the expected length, 1 and 2 the header bytes. Unknown indexes are ignored.
// Reset clears the frame state and the output, and restores the registers
// to a length of 64 and the header "SP".
// ----------------------------------------------------------------------------
module header_crc16_frame_checker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte [7:0]
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status [1:0], computed_crc [17:2],
                                 // received_crc [33:18], zeros [39:34]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  hcfc_pkg::cfg_t    cfg;
  hcfc_pkg::result_t result;
  hcfc_pkg::result_t out_data;
  logic              stage_valid;
  logic [7:0]        stage_byte;
  logic              stage_last;
  logic              stage_adv;
  logic              out_room;
  logic              out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_length <= hcfc_pkg::EXPECTED_LENGTH_RESET;
      cfg.header_first    <= hcfc_pkg::HEADER_FIRST_RESET;
      cfg.header_second   <= hcfc_pkg::HEADER_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcfc_pkg::REG_EXPECTED_LENGTH: begin
          cfg.expected_length <= cfg_data;
        end
        hcfc_pkg::REG_HEADER_FIRST: begin
          cfg.header_first <= cfg_data[7:0];
        end
        hcfc_pkg::REG_HEADER_SECOND: begin
          cfg.header_second <= cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_room  = !out_valid || m_tready;
  assign stage_adv = stage_valid && (!stage_last || out_room);
  assign s_tready  = !stage_valid || stage_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      stage_byte <= s_tdata;
      stage_last <= s_tlast;
    end
  end

  hcfc_check u_check (
    .clk       (clk),
    .rst       (rst),
    .step      (stage_adv),
    .data_byte (stage_byte),
    .last_byte (stage_last),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv && stage_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_last) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_data.received_crc, out_data.computed_crc, out_data.status};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !stage_valid)
    else $error("output or input stage not empty after reset");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> s_tready)
    else $error("input not ready with an empty input stage");

  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage_last && out_valid && !m_tready |=>
      stage_valid && stage_last && $stable(stage_byte))
    else $error("final byte left the input stage while the result was blocked");

  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(stage_adv && stage_last) |=> !m_tvalid)
    else $error("verdict appeared without a final byte");

endmodule

>>> sim/header_crc16_frame_checker_unit_tb.sv
// ----------------------------------------------------------------------------
// header_crc16_frame_checker_unit_tb
// Self-checking testbench for the header and CRC-16 frame checker. Frames are
// built with good or damaged headers, lengths and CRCs and streamed in byte by
// byte under several idling patterns. A running model of the checker predicts
// each verdict word, which is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module header_crc16_frame_checker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int RANDOM_BYTES = 800;
  localparam int STALL_LIMIT = 3000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;

  header_crc16_frame_checker_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Checker model: registers and frame state.
  logic [9:0]        want_len = 10'd64;
  logic [7:0]        want_h1 = 8'h53;
  logic [7:0]        want_h2 = 8'h50;
  logic [15:0]       crc_run = 16'hFFFF;
  hcfc_pkg::count_t  bytes_seen = '0;
  logic [7:0]        delay_new = 8'h00;
  logic [7:0]        delay_old = 8'h00;
  logic              header_ok = 1'b1;

  hcfc_pkg::result_t verdicts_due[$];
  logic [7:0]        frame_buf[$];
  int                err_count = 0;
  int                bytes_sent = 0;
  int                src_idle_pct = 0;
  int                sink_stall_pct = 0;
  int                quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    hcfc_pkg::result_t want;
    hcfc_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = hcfc_pkg::result_t'(m_tdata[33:0]);
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict word %0h", m_tdata);
        err_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_count++;
        end
        if (got.computed_crc !== want.computed_crc) begin
          $error("computed_crc: expected %04h, got %04h", want.computed_crc,
                 got.computed_crc);
          err_count++;
        end
        if (got.received_crc !== want.received_crc) begin
          $error("received_crc: expected %04h, got %04h", want.received_crc,
                 got.received_crc);
          err_count++;
        end
        if (m_tdata[39:34] !== 6'd0) begin
          $error("padding: expected 0, got %0h", m_tdata[39:34]);
          err_count++;
        end
      end
    end
  end

  function automatic logic [15:0] crc_mcrf_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[15:1]} ^ (fb ? 16'h8408 : 16'h0000);
    end
    return c;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    hcfc_pkg::result_t v;
    hcfc_pkg::count_t  pos;
    int                flen;
    pos = bytes_seen;
    if (pos == 0 && b != want_h1) header_ok = 1'b0;
    if (pos == 1 && b != want_h2) header_ok = 1'b0;
    if (pos >= 2) crc_run = crc_mcrf_byte(crc_run, delay_old);
    if (!last) begin
      delay_old = delay_new;
      delay_new = b;
      if (bytes_seen != hcfc_pkg::COUNT_MAX) bytes_seen = bytes_seen + 1'b1;
      return;
    end
    flen = (pos < hcfc_pkg::COUNT_MAX) ? int'(pos) + 1 : int'(hcfc_pkg::COUNT_MAX);
    v.received_crc = {b, delay_new};
    v.computed_crc = crc_run;
    if (flen != int'(want_len)) begin
      v.status = hcfc_pkg::STATUS_LENGTH;
    end else if (!header_ok || flen < 2) begin
      v.status = hcfc_pkg::STATUS_HEADER;
    end else if (v.received_crc != crc_run) begin
      v.status = hcfc_pkg::STATUS_CRC;
    end else begin
      v.status = hcfc_pkg::STATUS_OK;
    end
    verdicts_due.push_back(v);
    crc_run = 16'hFFFF;
    bytes_seen = '0;
    delay_new = 8'h00;
    delay_old = 8'h00;
    header_ok = 1'b1;
  endfunction

  // Fills frame_buf with random payload, the configured header and a CRC over
  // all but the last two bytes, each optionally damaged.
  function automatic void build_frame(input int len, input bit bad_h1, input bit bad_h2,
                                      input bit bad_crc);
    logic [15:0] c;
    frame_buf.delete();
    for (int k = 0; k < len; k++) frame_buf.push_back(8'($urandom));
    if (len >= 1) frame_buf[0] = bad_h1 ? want_h1 ^ 8'($urandom_range(1, 255)) : want_h1;
    if (len >= 2) frame_buf[1] = bad_h2 ? want_h2 ^ 8'($urandom_range(1, 255)) : want_h2;
    if (len >= 4) begin
      c = 16'hFFFF;
      for (int k = 0; k < len - 2; k++) c = crc_mcrf_byte(c, frame_buf[k]);
      if (bad_crc) c = c ^ (16'd1 << $urandom_range(0, 15));
      frame_buf[len-2] = c[7:0];
      frame_buf[len-1] = c[15:8];
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    int n;
    n = frame_buf.size();
    for (int k = 0; k < n; k++) send_byte(frame_buf[k], k == n - 1);
  endtask

  task automatic settle(input int hold);
    s_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (hold) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      hcfc_pkg::REG_EXPECTED_LENGTH: want_len = val;
      hcfc_pkg::REG_HEADER_FIRST:    want_h1 = val[7:0];
      hcfc_pkg::REG_HEADER_SECOND:   want_h2 = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idle(input int src, input int sink);
    src_idle_pct = src;
    sink_stall_pct = sink;
  endtask

  task automatic test_reset_defaults();
    set_idle(0, 0);
    build_frame(64, 0, 0, 0);
    send_frame();
    settle(4);
  endtask

  task automatic test_short_frames();
    write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'd0);
    frame_buf = '{8'h00};
    send_frame();
    settle(4);
    write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'd1);
    frame_buf = '{8'hFF};
    send_frame();
    settle(4);
    write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'd2);
    write_reg(hcfc_pkg::REG_HEADER_FIRST, 10'h3FF);
    write_reg(hcfc_pkg::REG_HEADER_SECOND, 10'h3FF);
    frame_buf = '{8'hFF, 8'hFF};
    send_frame();
    frame_buf = '{8'hFF, 8'h00};
    send_frame();
    settle(4);
  endtask

  task automatic test_check_priority();
    write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'd4);
    write_reg(hcfc_pkg::REG_HEADER_FIRST, 10'h300);
    write_reg(hcfc_pkg::REG_HEADER_SECOND, 10'h300);
    write_reg(REG_UNMAPPED, 10'h3FF);
    build_frame(4, 0, 0, 0);
    send_frame();
    build_frame(4, 0, 0, 1);
    send_frame();
    build_frame(4, 1, 0, 1);
    send_frame();
    build_frame(5, 1, 0, 0);
    send_frame();
    settle(4);
  endtask

  task automatic test_pause_until_drained();
    set_idle(0, 53);
    for (int r = 0; r < 3; r++) begin
      build_frame(4, 0, 0, 0);
      send_frame();
      build_frame(4, 0, 1, 0);
      send_frame();
      settle($urandom_range(4, 30));
    end
  endtask

  task automatic send_random_frame();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    len = int'(want_len);
    if (kind < 65) begin
      build_frame(len, 0, 0, 0);
    end else if (kind < 73) begin
      build_frame(len, 1, 0, 0);
    end else if (kind < 80) begin
      build_frame(len, 0, 1, 0);
    end else if (kind < 88) begin
      build_frame(len, 0, 0, 1);
    end else if (kind < 95) begin
      build_frame($urandom_range(1, len + 4), 0, 0, 0);
    end else begin
      frame_buf.delete();
      repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
    end
    send_frame();
  endtask

  task automatic test_random_frames();
    int round;
    int first;
    round = 0;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      case (round % 4)
        0: set_idle(0, 0);
        1: set_idle(53, 0);
        2: set_idle(0, 53);
        default: set_idle(10, 10);
      endcase
      case (round % 5)
        0: begin
          write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'd4);
          write_reg(hcfc_pkg::REG_HEADER_FIRST, {2'($urandom), 8'h00});
          write_reg(hcfc_pkg::REG_HEADER_SECOND, {2'($urandom), 8'hFF});
        end
        1: begin
          write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'($urandom_range(5, 24)));
          write_reg(hcfc_pkg::REG_HEADER_FIRST, 10'($urandom));
          write_reg(hcfc_pkg::REG_HEADER_SECOND, 10'($urandom));
        end
        2: begin
          write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'($urandom_range(4, 12)));
          write_reg(hcfc_pkg::REG_HEADER_FIRST, {2'($urandom), 8'hFF});
          write_reg(hcfc_pkg::REG_HEADER_SECOND, {2'($urandom), 8'h00});
        end
        3: write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'($urandom_range(25, 60)));
        default: begin
          write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'($urandom_range(4, 16)));
          write_reg(hcfc_pkg::REG_HEADER_SECOND, 10'($urandom));
          write_reg(REG_UNMAPPED, 10'($urandom));
        end
      endcase
      repeat (10) send_random_frame();
      settle($urandom_range(4, 12));
      round++;
    end
  endtask

  // The byte count saturates, so any frame from the maximum length upwards
  // compares as the maximum.
  task automatic test_long_frames();
    set_idle(10, 10);
    write_reg(hcfc_pkg::REG_EXPECTED_LENGTH, 10'd1023);
    write_reg(hcfc_pkg::REG_HEADER_FIRST, 10'h053);
    write_reg(hcfc_pkg::REG_HEADER_SECOND, 10'h050);
    build_frame(1025, 0, 0, 0);
    send_frame();
    settle(4);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = 2'd0;
    cfg_data  = 10'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_short_frames();
    test_check_priority();
    test_pause_until_drained();
    test_random_frames();
    test_long_frames();
    settle(10);
    if (err_count == 0 && verdicts_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/hcfc_pkg.sv
rtl/core/hcfc_check.sv
rtl/core/header_crc16_frame_checker_unit.sv
sim/header_crc16_frame_checker_unit_tb.sv
